[sv/dhfd_pkg.sv]
// ----------------------------------------------------------------------------
// dhfd_pkg
// Shared types, constants and helpers of the dHash hold frame detector.
// ----------------------------------------------------------------------------
package dhfd_pkg;

   localparam int MAX_HASH_SIZE  = 8;
   localparam int HASH_W         = MAX_HASH_SIZE * MAX_HASH_SIZE;
   localparam int GROUP_W        = 8;
   localparam int GROUPS         = HASH_W / GROUP_W;
   localparam int PART_W         = $clog2(GROUP_W + 1);
   localparam int DIST_W         = 7;
   localparam int SIZE_W         = 4;
   localparam int PIXEL_W        = 8;
   localparam int INDEX_W        = 16;
   localparam int CSR_INDEX_W    = 8;
   localparam int CSR_DATA_W     = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_SIZE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = CSR_INDEX_W'(1);

   localparam logic [SIZE_W-1:0] HASH_SIZE_RESET = SIZE_W'(8);
   localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(4);

   // One completed frame on its way to the distance unit.
   typedef struct packed {
      logic [HASH_W-1:0]  diff;
      logic [INDEX_W-1:0] index;
      logic               have_prev;
   } frame_beat_type;

   function automatic logic [PART_W-1:0] group_ones(input logic [GROUP_W-1:0] v);
      logic [PART_W-1:0] n;
      n = '0;
      for (int i = 0; i < GROUP_W; i++) begin
         n = n + PART_W'(v[i]);
      end
      return n;
   endfunction

endpackage

[sv/dhfd_distance.sv]
// ----------------------------------------------------------------------------
// dhfd_distance
// Two-stage popcount of a frame's hash difference, hold decision and the
// result register.
// ----------------------------------------------------------------------------
module dhfd_distance (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 beat_valid,
   output logic                                 beat_ready,
   input  dhfd_pkg::frame_beat_type             beat,
   input  logic [dhfd_pkg::DIST_W-1:0]          threshold,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dhfd_pkg::INDEX_W-1:0]         rsp_frame_index,
   output logic [dhfd_pkg::DIST_W-1:0]          rsp_bit_distance,
   output logic                                 rsp_is_hold
);

   logic [dhfd_pkg::PART_W-1:0]  part_ff [dhfd_pkg::GROUPS];
   logic [dhfd_pkg::INDEX_W-1:0] part_index_ff;
   logic                         part_have_prev_ff;
   logic                         part_valid_ff;
   logic                         out_free;
   logic                         part_free;
   logic [dhfd_pkg::DIST_W-1:0]  dist_in;

   assign out_free   = !rsp_valid || rsp_ready;
   assign part_free  = !part_valid_ff || out_free;
   assign beat_ready = part_free;

   // partial counts, one per byte of the difference
   always_ff @(posedge clock) begin
      if (reset) begin
         part_valid_ff <= 1'b0;
      end else if (part_free) begin
         part_valid_ff <= beat_valid;
      end
      if (part_free && beat_valid) begin
         for (int g = 0; g < dhfd_pkg::GROUPS; g++) begin
            part_ff[g] <= dhfd_pkg::group_ones(
               beat.diff[g*dhfd_pkg::GROUP_W +: dhfd_pkg::GROUP_W]);
         end
         part_index_ff     <= beat.index;
         part_have_prev_ff <= beat.have_prev;
      end
   end

   always_comb begin
      dist_in = '0;
      for (int g = 0; g < dhfd_pkg::GROUPS; g++) begin
         dist_in = dist_in + dhfd_pkg::DIST_W'(part_ff[g]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_free) begin
         rsp_valid <= part_valid_ff;
      end
      if (out_free && part_valid_ff) begin
         rsp_frame_index  <= part_index_ff;
         rsp_bit_distance <= dist_in;
         rsp_is_hold      <= part_have_prev_ff && (dist_in <= threshold);
      end
   end

endmodule

[sv/dhash_hold_frame_detector_unit.sv]
// ----------------------------------------------------------------------------
// dhash_hold_frame_detector_unit
// Difference-hash of streamed thumbnails and Hamming distance to the
// previous frame, flagging hold frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one grey pixel per beat, raster order. A frame is N rows of N+1
//            pixels, N being the frame size register clamped into 1..8; each pixel after the
//            first in a row adds one hash bit (brighter than its left neighbor).
//   rsp_*  : one beat per completed frame: frame index (wraps at 16 bits),
//            popcount of the hash difference against the previous frame and
//            the hold flag (distance within threshold, never the first frame).
//   csr_*  : register writes, index 0 frame size, index 1 hamming_threshold;
//            other indexes are dropped. Always ready.
// Timing: one pixel per cycle while req_ready stays high. After the edge that
//   takes a frame's last pixel, the frame register loads, then the partial
//   popcount register, then the result register, which raises rsp_valid.
// Reset: synchronous; the frame size returns to 8, threshold to 4, all hash
//   state, counters and the frame index clear, no frame is seen yet.
// Stall: a stalled rsp_* holds its beat; the popcount stages fill and then
//   req_ready drops until a stage frees up.
// ----------------------------------------------------------------------------
module dhash_hold_frame_detector_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dhfd_pkg::PIXEL_W-1:0]         req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dhfd_pkg::INDEX_W-1:0]         rsp_frame_index,
   output logic [dhfd_pkg::DIST_W-1:0]          rsp_bit_distance,
   output logic                                 rsp_is_hold,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dhfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dhfd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration
   logic [dhfd_pkg::SIZE_W-1:0]  size_cfg_ff;
   logic [dhfd_pkg::DIST_W-1:0]  threshold_ff;

   // hashing state
   logic [dhfd_pkg::PIXEL_W-1:0] left_pixel_ff;
   logic [dhfd_pkg::SIZE_W-1:0]  column_ff, column_in;
   logic [dhfd_pkg::SIZE_W-1:0]  row_ff, row_in;
   logic [dhfd_pkg::HASH_W-1:0]  current_ff, current_in;
   logic [dhfd_pkg::HASH_W-1:0]  previous_ff;
   logic                         have_prev_ff;
   logic [dhfd_pkg::INDEX_W-1:0] frame_ff;

   // frame beat towards the distance unit
   logic                         beat_valid_ff;
   dhfd_pkg::frame_beat_type     beat_ff;
   logic                         beat_ready;

   logic [dhfd_pkg::SIZE_W-1:0]  eff_size;
   logic [dhfd_pkg::SIZE_W-1:0]  column_inc;
   logic [dhfd_pkg::SIZE_W-1:0]  row_inc;
   logic [dhfd_pkg::HASH_W-1:0]  hash_shifted;
   logic                         row_end;
   logic                         frame_end;
   logic                         accept;

   assign csr_ready = 1'b1;
   assign req_ready = !beat_valid_ff || beat_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_cfg_ff  <= dhfd_pkg::HASH_SIZE_RESET;
         threshold_ff <= dhfd_pkg::THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            dhfd_pkg::CSR_HASH_SIZE: size_cfg_ff  <= csr_wdata[dhfd_pkg::SIZE_W-1:0];
            dhfd_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[dhfd_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the size into 1..MAX_HASH_SIZE
   always_comb begin
      eff_size = size_cfg_ff;
      if (size_cfg_ff == '0) begin
         eff_size = dhfd_pkg::SIZE_W'(1);
      end else if (size_cfg_ff > dhfd_pkg::SIZE_W'(dhfd_pkg::MAX_HASH_SIZE)) begin
         eff_size = dhfd_pkg::SIZE_W'(dhfd_pkg::MAX_HASH_SIZE);
      end
   end

   // next hash, column and row; ends compare with >= so a shrunk size
   // closes a row or frame at the next pixel
   always_comb begin
      hash_shifted = current_ff;
      if (column_ff != '0) begin
         hash_shifted = {current_ff[dhfd_pkg::HASH_W-2:0], req_pixel > left_pixel_ff};
      end
      column_inc = column_ff + dhfd_pkg::SIZE_W'(1);
      row_inc    = row_ff + dhfd_pkg::SIZE_W'(1);
      row_end    = {1'b0, column_inc} >= ({1'b0, eff_size} + 5'd1);
      frame_end  = row_end && (row_inc >= eff_size);
      column_in  = row_end ? '0 : column_inc;
      row_in     = row_end ? (frame_end ? '0 : row_inc) : row_ff;
      current_in = frame_end ? '0 : hash_shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_pixel_ff <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         current_ff    <= '0;
         previous_ff   <= '0;
         have_prev_ff  <= 1'b0;
         frame_ff      <= '0;
      end else if (accept) begin
         left_pixel_ff <= req_pixel;
         column_ff     <= column_in;
         row_ff        <= row_in;
         current_ff    <= current_in;
         if (frame_end) begin
            previous_ff  <= hash_shifted;
            have_prev_ff <= 1'b1;
            frame_ff     <= frame_ff + dhfd_pkg::INDEX_W'(1);
         end
      end
   end

   // hold the completed frame's difference until the distance unit takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
      end else if (req_ready) begin
         beat_valid_ff <= accept && frame_end;
      end
      if (accept && frame_end) begin
         beat_ff.diff      <= hash_shifted ^ previous_ff;
         beat_ff.index     <= frame_ff;
         beat_ff.have_prev <= have_prev_ff;
      end
   end

   dhfd_distance u_distance (
      .clock            (clock),
      .reset            (reset),
      .beat_valid       (beat_valid_ff),
      .beat_ready       (beat_ready),
      .beat             (beat_ff),
      .threshold        (threshold_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_bit_distance (rsp_bit_distance),
      .rsp_is_hold      (rsp_is_hold)
   );

endmodule
